[rtl/core/lrmp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lrmp_pkg: shared types and constants of the replication message parser
// Parse steps, record layout, message kinds, status codes and defaults.
// ---------------------------------------------------------------------------
package lrmp_pkg;

  localparam int unsigned OffsetWidthDefault = 32;
  localparam int unsigned FifoDepthDefault   = 4;

  typedef enum logic [5:0] {
    ST_TAG, ST_DONE, ST_ERR, ST_B_LSN, ST_B_TIME, ST_B_XID, ST_C_FLAGS, ST_C_LSN,
    ST_C_END, ST_C_TIME, ST_R_ID, ST_R_NSP, ST_R_NAME, ST_R_IDENT, ST_R_NATTS,
    ST_R_CFLAGS, ST_R_CNAME, ST_R_CTYPE, ST_R_CMOD, ST_REL_ID, ST_I_SUB, ST_U_SUB1,
    ST_U_SUB2, ST_D_SUB, ST_T_N, ST_T_FLAGS, ST_T_REL, ST_Y_OID, ST_Y_NSP,
    ST_Y_NAME, ST_O_LSN, ST_O_NAME, ST_TP_NCOLS, ST_TP_KIND, ST_TP_LEN, ST_TP_DATA
  } step_t;

  localparam logic [7:0] TAG_BEGIN  = "B";
  localparam logic [7:0] TAG_COMMIT = "C";
  localparam logic [7:0] TAG_REL    = "R";
  localparam logic [7:0] TAG_INS    = "I";
  localparam logic [7:0] TAG_UPD    = "U";
  localparam logic [7:0] TAG_DEL    = "D";
  localparam logic [7:0] TAG_TRUNC  = "T";
  localparam logic [7:0] TAG_TYPE   = "Y";
  localparam logic [7:0] TAG_ORIGIN = "O";
  localparam logic [7:0] TAG_MSG    = "M";
  localparam logic [7:0] SUB_NEW    = "N";
  localparam logic [7:0] SUB_KEY    = "K";
  localparam logic [7:0] SUB_OLD    = "O";
  localparam logic [7:0] COL_TEXT   = "t";
  localparam logic [7:0] COL_BIN    = "b";
  localparam logic [7:0] COL_NULL   = "n";
  localparam logic [7:0] COL_UNCH   = "u";

  localparam logic [3:0] MSG_BEGIN    = 4'd0;
  localparam logic [3:0] MSG_COMMIT   = 4'd1;
  localparam logic [3:0] MSG_RELATION = 4'd2;
  localparam logic [3:0] MSG_INSERT   = 4'd3;
  localparam logic [3:0] MSG_UPDATE   = 4'd4;
  localparam logic [3:0] MSG_DELETE   = 4'd5;
  localparam logic [3:0] MSG_TRUNCATE = 4'd6;
  localparam logic [3:0] MSG_TYPE     = 4'd7;
  localparam logic [3:0] MSG_ORIGIN   = 4'd8;
  localparam logic [3:0] MSG_IGNORED  = 4'd9;
  localparam logic [3:0] MSG_UNKNOWN  = 4'd10;

  localparam logic [4:0] FC_FINAL_LSN  = 5'd0;
  localparam logic [4:0] FC_TIME       = 5'd1;
  localparam logic [4:0] FC_XID        = 5'd2;
  localparam logic [4:0] FC_CFLAGS     = 5'd3;
  localparam logic [4:0] FC_COMMIT_LSN = 5'd4;
  localparam logic [4:0] FC_END_LSN    = 5'd5;
  localparam logic [4:0] FC_REL_ID     = 5'd6;
  localparam logic [4:0] FC_NSP        = 5'd7;
  localparam logic [4:0] FC_REL_NAME   = 5'd8;
  localparam logic [4:0] FC_IDENT      = 5'd9;
  localparam logic [4:0] FC_NATTS      = 5'd10;
  localparam logic [4:0] FC_COL_FLAGS  = 5'd11;
  localparam logic [4:0] FC_COL_NAME   = 5'd12;
  localparam logic [4:0] FC_TYPE_OID   = 5'd13;
  localparam logic [4:0] FC_TYPE_MOD   = 5'd14;
  localparam logic [4:0] FC_NEW_TUPLE  = 5'd15;
  localparam logic [4:0] FC_KEY_TUPLE  = 5'd16;
  localparam logic [4:0] FC_OLD_TUPLE  = 5'd17;
  localparam logic [4:0] FC_TRUNC_N    = 5'd18;
  localparam logic [4:0] FC_TRUNC_FLAG = 5'd19;
  localparam logic [4:0] FC_TYPE_NAME  = 5'd20;
  localparam logic [4:0] FC_ORIGIN_LSN = 5'd21;
  localparam logic [4:0] FC_ORIGIN_NAME = 5'd22;
  localparam logic [4:0] FC_CLOSE      = 5'd23;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_TRUNC     = 3'd1;
  localparam logic [2:0] STS_UNTERM    = 3'd2;
  localparam logic [2:0] STS_BAD_KIND  = 3'd3;
  localparam logic [2:0] STS_NO_INS    = 3'd4;
  localparam logic [2:0] STS_NO_UPD    = 3'd5;
  localparam logic [2:0] STS_NO_DEL    = 3'd6;
  localparam logic [2:0] STS_BAD_TAG   = 3'd7;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  message_type;
    logic [4:0]  field_code;
    logic [63:0] field_value;
    logic [31:0] region_length;
    logic [2:0]  status;
    logic        end_of_message;
  } rec_t;

  // up to two records caused by one byte
  typedef struct packed {
    logic       has_a;
    logic       has_b;
    rec_t       a;
    rec_t       b;
  } pair_t;

  function automatic logic is_string_step(step_t s);
    return s == ST_R_NSP || s == ST_R_NAME || s == ST_R_CNAME ||
           s == ST_Y_NSP || s == ST_Y_NAME || s == ST_O_NAME;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lrmp_stream_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lrmp_stream_if: valid/ready channel carrying one payload type
// Source drives valid and payload, sink drives ready.
// ---------------------------------------------------------------------------
interface lrmp_stream_if #(parameter type payload_t = logic [7:0]) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/lrmp_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lrmp_front: byte parser
// Walks the message layout one byte a cycle while the queue has room and produces up to two records per byte.
// ---------------------------------------------------------------------------
module lrmp_front
  import lrmp_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OffsetWidthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] payload_byte,
  input  wire logic       last_byte,
  input  wire logic       q_space,
  output logic            q_push,
  output pair_t           q_data
);

  step_t parse_step, parse_step_next;
  logic [3:0]  kind_of_message, kind_next;
  logic [2:0]  byte_in_field, bif_next;
  logic [63:0] field_accumulator, acc_next;
  logic [OFFSET_WIDTH-1:0] byte_position, region_start, rs_next;
  logic [31:0] loop_count, lc_next, skip_remaining, skip_next;
  logic [2:0]  error_code, err_next;
  logic [4:0]  tuple_code, tc_next;

  logic        fire;
  logic [63:0] acc_shift;
  logic [2:0]  nbytes_m1;
  logic        int_done;
  logic        emit;
  logic [4:0]  emit_code;
  logic [63:0] emit_val;
  logic [OFFSET_WIDTH-1:0] emit_len, pos_inc;
  logic [2:0]  close_status;
  logic [31:0] lc_dec, skip_dec;
  step_t       go_to;
  logic        go_en;

  assign fire = in_valid && in_ready;
  assign in_ready = q_space;
  assign acc_shift = {field_accumulator[55:0], payload_byte};
  assign pos_inc = byte_position + OFFSET_WIDTH'(1);
  assign lc_dec = loop_count - 32'd1;
  assign skip_dec = skip_remaining - 32'd1;

  always_comb begin
    case (parse_step)
      ST_B_LSN, ST_B_TIME, ST_C_LSN, ST_C_END, ST_C_TIME, ST_O_LSN: nbytes_m1 = 3'd7;
      ST_R_NATTS, ST_TP_NCOLS: nbytes_m1 = 3'd1;
      default: nbytes_m1 = 3'd3;
    endcase
  end
  assign int_done = byte_in_field == nbytes_m1;

  always_comb begin
    kind_next = kind_of_message;
    bif_next = byte_in_field;
    acc_next = field_accumulator;
    lc_next = loop_count;
    skip_next = skip_remaining;
    err_next = error_code;
    tc_next = tuple_code;
    go_en = 1'b0;
    go_to = parse_step;
    emit = 1'b0;
    emit_code = FC_FINAL_LSN;
    emit_val = '0;
    emit_len = '0;
    case (parse_step)
      ST_B_LSN, ST_B_TIME, ST_B_XID, ST_C_LSN, ST_C_END, ST_C_TIME, ST_R_ID,
      ST_R_NATTS, ST_R_CTYPE, ST_R_CMOD, ST_REL_ID, ST_T_N, ST_T_REL, ST_Y_OID,
      ST_O_LSN, ST_TP_NCOLS, ST_TP_LEN: begin
        if (int_done) begin
          acc_next = '0;
          bif_next = '0;
        end else begin
          acc_next = acc_shift;
          bif_next = byte_in_field + 3'd1;
        end
      end
      default: ;
    endcase
    emit_val = acc_shift;
    case (parse_step)
      ST_TAG: begin
        go_en = 1'b1;
        case (payload_byte)
          TAG_BEGIN: begin kind_next = MSG_BEGIN; go_to = ST_B_LSN; end
          TAG_COMMIT: begin kind_next = MSG_COMMIT; go_to = ST_C_FLAGS; end
          TAG_REL: begin kind_next = MSG_RELATION; go_to = ST_R_ID; end
          TAG_INS: begin kind_next = MSG_INSERT; go_to = ST_REL_ID; end
          TAG_UPD: begin kind_next = MSG_UPDATE; go_to = ST_REL_ID; end
          TAG_DEL: begin kind_next = MSG_DELETE; go_to = ST_REL_ID; end
          TAG_TRUNC: begin kind_next = MSG_TRUNCATE; go_to = ST_T_N; end
          TAG_TYPE: begin kind_next = MSG_TYPE; go_to = ST_Y_OID; end
          TAG_ORIGIN: begin kind_next = MSG_ORIGIN; go_to = ST_O_LSN; end
          TAG_MSG: begin kind_next = MSG_IGNORED; go_to = ST_DONE; end
          default: begin kind_next = MSG_UNKNOWN; go_to = ST_ERR; err_next = STS_BAD_TAG; end
        endcase
      end
      ST_B_LSN: if (int_done) begin emit = 1'b1; emit_code = FC_FINAL_LSN; go_en = 1'b1; go_to = ST_B_TIME; end
      ST_B_TIME: if (int_done) begin emit = 1'b1; emit_code = FC_TIME; go_en = 1'b1; go_to = ST_B_XID; end
      ST_B_XID: if (int_done) begin emit = 1'b1; emit_code = FC_XID; go_en = 1'b1; go_to = ST_DONE; end
      ST_C_FLAGS: begin emit = 1'b1; emit_code = FC_CFLAGS; emit_val = 64'(payload_byte); go_en = 1'b1; go_to = ST_C_LSN; end
      ST_C_LSN: if (int_done) begin emit = 1'b1; emit_code = FC_COMMIT_LSN; go_en = 1'b1; go_to = ST_C_END; end
      ST_C_END: if (int_done) begin emit = 1'b1; emit_code = FC_END_LSN; go_en = 1'b1; go_to = ST_C_TIME; end
      ST_C_TIME: if (int_done) begin emit = 1'b1; emit_code = FC_TIME; go_en = 1'b1; go_to = ST_DONE; end
      ST_R_ID: if (int_done) begin emit = 1'b1; emit_code = FC_REL_ID; go_en = 1'b1; go_to = ST_R_NSP; end
      ST_R_NSP, ST_R_NAME, ST_R_CNAME, ST_Y_NSP, ST_Y_NAME, ST_O_NAME: begin
        if (payload_byte == 8'h00) begin
          emit = 1'b1;
          emit_val = 64'(region_start);
          emit_len = byte_position - region_start;
          go_en = 1'b1;
          case (parse_step)
            ST_R_NSP: begin emit_code = FC_NSP; go_to = ST_R_NAME; end
            ST_R_NAME: begin emit_code = FC_REL_NAME; go_to = ST_R_IDENT; end
            ST_R_CNAME: begin emit_code = FC_COL_NAME; go_to = ST_R_CTYPE; end
            ST_Y_NSP: begin emit_code = FC_NSP; go_to = ST_Y_NAME; end
            ST_Y_NAME: begin emit_code = FC_TYPE_NAME; go_to = ST_DONE; end
            default: begin emit_code = FC_ORIGIN_NAME; go_to = ST_DONE; end
          endcase
        end
      end
      ST_R_IDENT: begin emit = 1'b1; emit_code = FC_IDENT; emit_val = 64'(payload_byte); go_en = 1'b1; go_to = ST_R_NATTS; end
      ST_R_NATTS: if (int_done) begin
        emit = 1'b1; emit_code = FC_NATTS; lc_next = 32'(acc_shift[15:0]);
        go_en = 1'b1; go_to = (acc_shift[15:0] != 16'd0) ? ST_R_CFLAGS : ST_DONE;
      end
      ST_R_CFLAGS: begin emit = 1'b1; emit_code = FC_COL_FLAGS; emit_val = 64'(payload_byte); go_en = 1'b1; go_to = ST_R_CNAME; end
      ST_R_CTYPE: if (int_done) begin emit = 1'b1; emit_code = FC_TYPE_OID; go_en = 1'b1; go_to = ST_R_CMOD; end
      ST_R_CMOD: if (int_done) begin
        emit = 1'b1; emit_code = FC_TYPE_MOD; lc_next = lc_dec;
        go_en = 1'b1; go_to = (lc_dec != 32'd0) ? ST_R_CFLAGS : ST_DONE;
      end
      ST_REL_ID: if (int_done) begin
        emit = 1'b1; emit_code = FC_REL_ID; go_en = 1'b1;
        go_to = (kind_of_message == MSG_INSERT) ? ST_I_SUB :
                (kind_of_message == MSG_UPDATE) ? ST_U_SUB1 : ST_D_SUB;
      end
      ST_I_SUB, ST_U_SUB1, ST_U_SUB2, ST_D_SUB: begin
        go_en = 1'b1; go_to = ST_TP_NCOLS;
        if (payload_byte == SUB_NEW && parse_step != ST_D_SUB) tc_next = FC_NEW_TUPLE;
        else if (payload_byte == SUB_KEY && (parse_step == ST_U_SUB1 || parse_step == ST_D_SUB))
          tc_next = FC_KEY_TUPLE;
        else if (payload_byte == SUB_OLD && (parse_step == ST_U_SUB1 || parse_step == ST_D_SUB))
          tc_next = FC_OLD_TUPLE;
        else begin
          go_to = ST_ERR;
          err_next = (parse_step == ST_I_SUB) ? STS_NO_INS :
                     (parse_step == ST_D_SUB) ? STS_NO_DEL : STS_NO_UPD;
        end
      end
      ST_T_N: if (int_done) begin
        emit = 1'b1; emit_code = FC_TRUNC_N; lc_next = acc_shift[31:0]; go_en = 1'b1; go_to = ST_T_FLAGS;
      end
      ST_T_FLAGS: begin
        emit = 1'b1; emit_code = FC_TRUNC_FLAG; emit_val = 64'(payload_byte); go_en = 1'b1;
        go_to = (loop_count != 32'd0) ? ST_T_REL : ST_DONE;
      end
      ST_T_REL: if (int_done) begin
        emit = 1'b1; emit_code = FC_REL_ID; lc_next = lc_dec;
        if (lc_dec == 32'd0) begin go_en = 1'b1; go_to = ST_DONE; end
      end
      ST_Y_OID: if (int_done) begin emit = 1'b1; emit_code = FC_TYPE_OID; go_en = 1'b1; go_to = ST_Y_NSP; end
      ST_O_LSN: if (int_done) begin emit = 1'b1; emit_code = FC_ORIGIN_LSN; go_en = 1'b1; go_to = ST_O_NAME; end
      ST_TP_NCOLS, ST_TP_KIND, ST_TP_LEN, ST_TP_DATA: begin
        logic col_end;
        logic tup_end;
        col_end = 1'b0;
        tup_end = 1'b0;
        case (parse_step)
          ST_TP_NCOLS: if (int_done) begin
            lc_next = 32'(acc_shift[15:0]);
            if (acc_shift[15:0] == 16'd0) tup_end = 1'b1;
            else begin go_en = 1'b1; go_to = ST_TP_KIND; end
          end
          ST_TP_KIND: begin
            if (payload_byte == COL_TEXT || payload_byte == COL_BIN) begin
              go_en = 1'b1; go_to = ST_TP_LEN;
            end else if (payload_byte == COL_NULL || payload_byte == COL_UNCH) col_end = 1'b1;
            else begin go_en = 1'b1; go_to = ST_ERR; err_next = STS_BAD_KIND; end
          end
          ST_TP_LEN: if (int_done) begin
            skip_next = acc_shift[31:0];
            if (acc_shift[31:0] == 32'd0) col_end = 1'b1;
            else begin go_en = 1'b1; go_to = ST_TP_DATA; end
          end
          default: begin
            skip_next = skip_dec;
            if (skip_dec == 32'd0) col_end = 1'b1;
          end
        endcase
        if (col_end) begin
          lc_next = lc_dec;
          if (lc_dec == 32'd0) tup_end = 1'b1;
          else begin go_en = 1'b1; go_to = ST_TP_KIND; end
        end
        if (tup_end) begin
          emit = 1'b1; emit_code = tuple_code; emit_val = 64'(region_start);
          emit_len = pos_inc - region_start;
          go_en = 1'b1;
          go_to = (kind_of_message == MSG_UPDATE && tuple_code != FC_NEW_TUPLE) ? ST_U_SUB2 : ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    parse_step_next = go_en ? go_to : parse_step;
    rs_next = region_start;
    if (go_en && go_to != parse_step && (is_string_step(go_to) || go_to == ST_TP_NCOLS))
      rs_next = pos_inc;
  end

  always_comb begin
    if (err_next != STS_OK) close_status = err_next;
    else if (parse_step_next == ST_DONE) close_status = STS_OK;
    else if (is_string_step(parse_step_next)) close_status = STS_UNTERM;
    else close_status = STS_TRUNC;
  end

  always_comb begin
    q_push = fire && (emit || last_byte);
    q_data.has_a = emit || last_byte;
    q_data.has_b = emit && last_byte;
    q_data.a.message_type = kind_next;
    q_data.a.field_code = emit ? emit_code : FC_CLOSE;
    q_data.a.field_value = emit ? emit_val : 64'd0;
    q_data.a.region_length = emit ? 32'(emit_len) : 32'd0;
    q_data.a.status = emit ? STS_OK : close_status;
    q_data.a.end_of_message = !emit;
    q_data.b.message_type = kind_next;
    q_data.b.field_code = FC_CLOSE;
    q_data.b.field_value = '0;
    q_data.b.region_length = '0;
    q_data.b.status = close_status;
    q_data.b.end_of_message = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      parse_step <= ST_TAG;
      kind_of_message <= '0;
      byte_in_field <= '0;
      field_accumulator <= '0;
      byte_position <= '0;
      loop_count <= '0;
      skip_remaining <= '0;
      region_start <= '0;
      error_code <= '0;
      tuple_code <= '0;
    end else if (fire) begin
      parse_step <= parse_step_next;
      kind_of_message <= kind_next;
      byte_in_field <= bif_next;
      field_accumulator <= acc_next;
      byte_position <= pos_inc;
      loop_count <= lc_next;
      skip_remaining <= skip_next;
      region_start <= rs_next;
      error_code <= err_next;
      tuple_code <= tc_next;
    end
  end

`ifndef SYNTHESIS
  a_err_state: assert property (@(posedge clk) disable iff (rst)
    (error_code != STS_OK) |-> (parse_step == ST_ERR)) else $error("error without err state");
  a_no_field_after_err: assert property (@(posedge clk) disable iff (rst)
    (q_push && parse_step == ST_ERR) |-> q_data.a.end_of_message) else $error("field after error");
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    (fire && last_byte) |-> q_push) else $error("missing close");
`endif

endmodule
`default_nettype wire

[rtl/core/lrmp_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lrmp_queue: record-pair queue and output serializer
// Holds parsed record pairs and hands them out one record per beat.
// ---------------------------------------------------------------------------
module lrmp_queue
  import lrmp_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  pair_t     push_data,
  output logic      space,
  output logic      out_valid,
  input  wire logic out_ready,
  output rec_t      out_rec
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pair_t             mem [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;
  logic              second;
  logic              pop;
  pair_t             head;

  assign head = mem[rd_ptr];
  assign space = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_rec = second ? head.b : head.a;
  assign pop = out_valid && out_ready && (second || !head.has_b);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      second <= 1'b0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
      if (pop) second <= 1'b0;
      else if (out_valid && out_ready) second <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space) else $error("queue overflow");
  a_second_has_b: assert property (@(posedge clk) disable iff (rst)
    second |-> (out_valid && head.has_b)) else $error("bad second record");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("count out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/logical_replication_message_parser_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// logical_replication_message_parser_core: pgoutput message parser
// One payload byte per beat in; field and closing records out. The parser
// takes a byte every cycle while the record queue has room; each byte
// causes up to two records, which leave one per cycle while the output
// is ready, so the sustained rate is one byte a cycle when bytes and
// records balance and the output side is the limit when a byte makes two
// records. Offsets wrap at OFFSET_WIDTH bits.
// ---------------------------------------------------------------------------
module logical_replication_message_parser_core
  import lrmp_pkg::*;
#(
  parameter int unsigned OFFSET_WIDTH = OffsetWidthDefault,
  parameter int unsigned FIFO_DEPTH   = FifoDepthDefault
) (
  input wire logic clk,
  input wire logic rst,
  lrmp_stream_if.sink   in_ch,
  lrmp_stream_if.source out_ch
);

  logic  q_space, q_push;
  pair_t q_data;
  rec_t  rec;

  lrmp_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .payload_byte(in_ch.payload.payload_byte), .last_byte(in_ch.payload.last_byte),
    .q_space, .q_push, .q_data
  );

  lrmp_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk, .rst, .push(q_push), .push_data(q_data), .space(q_space),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_rec(rec)
  );

  assign out_ch.payload = rec;

endmodule
`default_nettype wire

[verif/logical_replication_message_parser_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// logical_replication_message_parser_core_test: parser self-checking bench
// Feeds pgoutput messages one byte per beat: a short table of edge cases,
// then random well-formed, cut-short and corrupted messages. A local
// byte-level parser model predicts every field and closing record, and
// each output beat is compared against it in order.
// ---------------------------------------------------------------------------
module logical_replication_message_parser_core_test;
  import lrmp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  lrmp_stream_if #(.payload_t(in_beat_t)) in_ch (clk);
  lrmp_stream_if #(.payload_t(rec_t)) out_ch (clk);

  logical_replication_message_parser_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---- record predictor ----
  rec_t        pending_recs[$];
  step_t       p_step;
  logic [3:0]  p_kind;
  int unsigned p_nbyte;
  logic [63:0] p_acc;
  logic [31:0] p_pos, p_loops, p_skip, p_rstart;
  logic [2:0]  p_err;
  logic [4:0]  p_tuple;

  function automatic bit text_step(step_t s);
    return s inside {ST_R_NSP, ST_R_NAME, ST_R_CNAME, ST_Y_NSP, ST_Y_NAME, ST_O_NAME};
  endfunction

  function void parser_clear();
    p_step = ST_TAG; p_kind = '0; p_nbyte = 0; p_acc = '0; p_pos = '0;
    p_loops = '0; p_skip = '0; p_rstart = '0; p_err = STS_OK; p_tuple = '0;
  endfunction

  function void put_rec(logic [4:0] code, logic [63:0] v, logic [31:0] len,
                        logic [2:0] st, logic eom);
    rec_t r;
    r.message_type = p_kind; r.field_code = code; r.field_value = v;
    r.region_length = len; r.status = st; r.end_of_message = eom;
    pending_recs.insert(pending_recs.size(), r);
  endfunction

  function void go(step_t nx);
    if (nx != p_step && (text_step(nx) || nx == ST_TP_NCOLS)) p_rstart = p_pos + 1;
    p_step = nx;
  endfunction

  function void fail_with(logic [2:0] code);
    p_err = code;
    p_step = ST_ERR;
  endfunction

  function bit gather(logic [7:0] b, int unsigned n, output logic [63:0] v);
    p_acc = {p_acc[55:0], b};
    v = p_acc;
    if (p_nbyte + 1 >= n) begin
      p_acc = '0;
      p_nbyte = 0;
      return 1'b1;
    end
    p_nbyte++;
    return 1'b0;
  endfunction

  function void text_byte(logic [7:0] b, logic [4:0] code, step_t nx);
    if (b == 8'd0) begin
      put_rec(code, 64'(p_rstart), p_pos - p_rstart, STS_OK, 1'b0);
      go(nx);
    end
  endfunction

  function void open_tuple(logic [4:0] code);
    p_tuple = code;
    go(ST_TP_NCOLS);
  endfunction

  function void tuple_end();
    put_rec(p_tuple, 64'(p_rstart), p_pos + 1 - p_rstart, STS_OK, 1'b0);
    if (p_kind == MSG_UPDATE && p_tuple != FC_NEW_TUPLE) go(ST_U_SUB2);
    else go(ST_DONE);
  endfunction

  function void column_end();
    p_loops--;
    if (p_loops == 0) tuple_end();
    else go(ST_TP_KIND);
  endfunction

  function void parse_byte(logic [7:0] b, logic last);
    logic [63:0] v;
    logic [2:0] st;
    case (p_step)
      ST_TAG: begin
        case (b)
          TAG_BEGIN: begin p_kind = MSG_BEGIN; go(ST_B_LSN); end
          TAG_COMMIT: begin p_kind = MSG_COMMIT; go(ST_C_FLAGS); end
          TAG_REL: begin p_kind = MSG_RELATION; go(ST_R_ID); end
          TAG_INS: begin p_kind = MSG_INSERT; go(ST_REL_ID); end
          TAG_UPD: begin p_kind = MSG_UPDATE; go(ST_REL_ID); end
          TAG_DEL: begin p_kind = MSG_DELETE; go(ST_REL_ID); end
          TAG_TRUNC: begin p_kind = MSG_TRUNCATE; go(ST_T_N); end
          TAG_TYPE: begin p_kind = MSG_TYPE; go(ST_Y_OID); end
          TAG_ORIGIN: begin p_kind = MSG_ORIGIN; go(ST_O_LSN); end
          TAG_MSG: begin p_kind = MSG_IGNORED; go(ST_DONE); end
          default: begin p_kind = MSG_UNKNOWN; fail_with(STS_BAD_TAG); end
        endcase
      end
      ST_B_LSN: if (gather(b, 8, v)) begin put_rec(FC_FINAL_LSN, v, 0, 0, 0); go(ST_B_TIME); end
      ST_B_TIME: if (gather(b, 8, v)) begin put_rec(FC_TIME, v, 0, 0, 0); go(ST_B_XID); end
      ST_B_XID: if (gather(b, 4, v)) begin put_rec(FC_XID, v, 0, 0, 0); go(ST_DONE); end
      ST_C_FLAGS: begin put_rec(FC_CFLAGS, 64'(b), 0, 0, 0); go(ST_C_LSN); end
      ST_C_LSN: if (gather(b, 8, v)) begin put_rec(FC_COMMIT_LSN, v, 0, 0, 0); go(ST_C_END); end
      ST_C_END: if (gather(b, 8, v)) begin put_rec(FC_END_LSN, v, 0, 0, 0); go(ST_C_TIME); end
      ST_C_TIME: if (gather(b, 8, v)) begin put_rec(FC_TIME, v, 0, 0, 0); go(ST_DONE); end
      ST_R_ID: if (gather(b, 4, v)) begin put_rec(FC_REL_ID, v, 0, 0, 0); go(ST_R_NSP); end
      ST_R_NSP: text_byte(b, FC_NSP, ST_R_NAME);
      ST_R_NAME: text_byte(b, FC_REL_NAME, ST_R_IDENT);
      ST_R_IDENT: begin put_rec(FC_IDENT, 64'(b), 0, 0, 0); go(ST_R_NATTS); end
      ST_R_NATTS: if (gather(b, 2, v)) begin
        put_rec(FC_NATTS, v, 0, 0, 0);
        p_loops = v[31:0];
        go(p_loops != 0 ? ST_R_CFLAGS : ST_DONE);
      end
      ST_R_CFLAGS: begin put_rec(FC_COL_FLAGS, 64'(b), 0, 0, 0); go(ST_R_CNAME); end
      ST_R_CNAME: text_byte(b, FC_COL_NAME, ST_R_CTYPE);
      ST_R_CTYPE: if (gather(b, 4, v)) begin put_rec(FC_TYPE_OID, v, 0, 0, 0); go(ST_R_CMOD); end
      ST_R_CMOD: if (gather(b, 4, v)) begin
        put_rec(FC_TYPE_MOD, v, 0, 0, 0);
        p_loops--;
        go(p_loops != 0 ? ST_R_CFLAGS : ST_DONE);
      end
      ST_REL_ID: if (gather(b, 4, v)) begin
        put_rec(FC_REL_ID, v, 0, 0, 0);
        go(p_kind == MSG_INSERT ? ST_I_SUB : p_kind == MSG_UPDATE ? ST_U_SUB1 : ST_D_SUB);
      end
      ST_I_SUB: if (b == SUB_NEW) open_tuple(FC_NEW_TUPLE); else fail_with(STS_NO_INS);
      ST_U_SUB1: begin
        if (b == SUB_KEY) open_tuple(FC_KEY_TUPLE);
        else if (b == SUB_OLD) open_tuple(FC_OLD_TUPLE);
        else if (b == SUB_NEW) open_tuple(FC_NEW_TUPLE);
        else fail_with(STS_NO_UPD);
      end
      ST_U_SUB2: if (b == SUB_NEW) open_tuple(FC_NEW_TUPLE); else fail_with(STS_NO_UPD);
      ST_D_SUB: begin
        if (b == SUB_KEY) open_tuple(FC_KEY_TUPLE);
        else if (b == SUB_OLD) open_tuple(FC_OLD_TUPLE);
        else fail_with(STS_NO_DEL);
      end
      ST_T_N: if (gather(b, 4, v)) begin
        put_rec(FC_TRUNC_N, v, 0, 0, 0);
        p_loops = v[31:0];
        go(ST_T_FLAGS);
      end
      ST_T_FLAGS: begin put_rec(FC_TRUNC_FLAG, 64'(b), 0, 0, 0); go(p_loops != 0 ? ST_T_REL : ST_DONE); end
      ST_T_REL: if (gather(b, 4, v)) begin
        put_rec(FC_REL_ID, v, 0, 0, 0);
        p_loops--;
        if (p_loops == 0) go(ST_DONE);
      end
      ST_Y_OID: if (gather(b, 4, v)) begin put_rec(FC_TYPE_OID, v, 0, 0, 0); go(ST_Y_NSP); end
      ST_Y_NSP: text_byte(b, FC_NSP, ST_Y_NAME);
      ST_Y_NAME: text_byte(b, FC_TYPE_NAME, ST_DONE);
      ST_O_LSN: if (gather(b, 8, v)) begin put_rec(FC_ORIGIN_LSN, v, 0, 0, 0); go(ST_O_NAME); end
      ST_O_NAME: text_byte(b, FC_ORIGIN_NAME, ST_DONE);
      ST_TP_NCOLS: if (gather(b, 2, v)) begin
        p_loops = v[31:0];
        if (p_loops == 0) tuple_end(); else go(ST_TP_KIND);
      end
      ST_TP_KIND: begin
        if (b == COL_TEXT || b == COL_BIN) go(ST_TP_LEN);
        else if (b == COL_NULL || b == COL_UNCH) column_end();
        else fail_with(STS_BAD_KIND);
      end
      ST_TP_LEN: if (gather(b, 4, v)) begin
        p_skip = v[31:0];
        if (p_skip == 0) column_end(); else go(ST_TP_DATA);
      end
      ST_TP_DATA: begin
        p_skip--;
        if (p_skip == 0) column_end();
      end
      default: ;
    endcase
    if (last) begin
      if (p_err != STS_OK) st = p_err;
      else if (p_step == ST_DONE) st = STS_OK;
      else if (text_step(p_step)) st = STS_UNTERM;
      else st = STS_TRUNC;
      put_rec(FC_CLOSE, '0, '0, st, 1'b1);
      parser_clear();
    end else begin
      p_pos++;
    end
  endfunction

  // ---- checking ----
  bit failed;
  bit use_typed;
  rec_t typed_close;
  int unsigned idle_cycles, beats_in, recs_out, msgs_sent;

  always @(posedge clk) begin
    rec_t e, a;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        beats_in++;
        parse_byte(in_ch.payload.payload_byte, in_ch.payload.last_byte);
        if (use_typed && in_ch.payload.last_byte)
          pending_recs[pending_recs.size() - 1] = typed_close;
      end
      if (out_ch.valid && out_ch.ready) begin
        recs_out++;
        a = out_ch.payload;
        if (pending_recs.size() == 0) begin
          $error("unexpected record: code %0d value %0h", a.field_code, a.field_value);
          failed = 1'b1;
        end else begin
          e = pending_recs.pop_front();
          if (a.message_type !== e.message_type) begin
            $error("message_type exp %0d got %0d", e.message_type, a.message_type); failed = 1'b1;
          end
          if (a.field_code !== e.field_code) begin
            $error("field_code exp %0d got %0d", e.field_code, a.field_code); failed = 1'b1;
          end
          if (a.field_value !== e.field_value) begin
            $error("field_value exp %0h got %0h", e.field_value, a.field_value); failed = 1'b1;
          end
          if (a.region_length !== e.region_length) begin
            $error("region_length exp %0d got %0d", e.region_length, a.region_length);
            failed = 1'b1;
          end
          if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); failed = 1'b1;
          end
          if (a.end_of_message !== e.end_of_message) begin
            $error("end_of_message exp %0b got %0b", e.end_of_message, a.end_of_message);
            failed = 1'b1;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d records pending",
                 IDLE_LIMIT, pending_recs.size());
        $display("logical_replication_message_parser_core: mismatch");
        $finish;
      end
    end
  end

  // ---- receiver ----
  bit no_idle, hold_req;

  initial begin
    int unsigned n;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- sender ----
  task automatic send_beat(logic [7:0] b, logic last);
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{payload_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  logic [7:0] msg[$];

  function void add_int(int unsigned nbytes);
    repeat (nbytes) msg.insert(msg.size(), 8'($urandom));
  endfunction

  function void add_count(int unsigned nbytes, int unsigned val);
    for (int i = nbytes - 1; i >= 0; i--) msg.insert(msg.size(), 8'(val >> (8 * i)));
  endfunction

  function void add_text();
    repeat ($urandom_range(0, 4)) msg.insert(msg.size(), 8'($urandom_range(1, 255)));
    msg.insert(msg.size(), 8'd0);
  endfunction

  function void add_tuple();
    int unsigned ncols, len;
    ncols = $urandom_range(0, 3);
    add_count(2, ncols);
    repeat (ncols) begin
      case ($urandom_range(0, 3))
        0: msg.insert(msg.size(), COL_NULL);
        1: msg.insert(msg.size(), COL_UNCH);
        default: begin
          msg.insert(msg.size(), $urandom_range(0, 1) ? COL_TEXT : COL_BIN);
          len = $urandom_range(0, 4);
          add_count(4, len);
          add_int(len);
        end
      endcase
    end
  endfunction

  function void build_message();
    int unsigned n, cut;
    msg.delete();
    case ($urandom_range(0, 10))
      0: begin msg.insert(msg.size(), TAG_BEGIN); add_int(20); end
      1: begin msg.insert(msg.size(), TAG_COMMIT); add_int(25); end
      2: begin
        msg.insert(msg.size(), TAG_REL); add_int(4); add_text(); add_text(); add_int(1);
        n = $urandom_range(0, 3);
        add_count(2, n);
        repeat (n) begin add_int(1); add_text(); add_int(8); end
      end
      3: begin
        msg.insert(msg.size(), TAG_INS); add_int(4); msg.insert(msg.size(), SUB_NEW);
        add_tuple();
      end
      4: begin
        msg.insert(msg.size(), TAG_UPD); add_int(4);
        case ($urandom_range(0, 2))
          0: begin msg.insert(msg.size(), SUB_KEY); add_tuple(); end
          1: begin msg.insert(msg.size(), SUB_OLD); add_tuple(); end
          default: ;
        endcase
        msg.insert(msg.size(), SUB_NEW); add_tuple();
      end
      5: begin
        msg.insert(msg.size(), TAG_DEL); add_int(4);
        msg.insert(msg.size(), $urandom_range(0, 1) ? SUB_KEY : SUB_OLD); add_tuple();
      end
      6: begin
        msg.insert(msg.size(), TAG_TRUNC);
        n = $urandom_range(0, 3);
        add_count(4, n); add_int(1); add_int(4 * n);
      end
      7: begin msg.insert(msg.size(), TAG_TYPE); add_int(4); add_text(); add_text(); end
      8: begin msg.insert(msg.size(), TAG_ORIGIN); add_int(8); add_text(); end
      9: begin msg.insert(msg.size(), TAG_MSG); add_int($urandom_range(0, 6)); end
      default: begin msg.insert(msg.size(), 8'($urandom)); add_int($urandom_range(0, 8)); end
    endcase
    case ($urandom_range(0, 9))
      0: add_int($urandom_range(1, 4));
      1: if (msg.size() > 1) begin
        cut = $urandom_range(1, msg.size() - 1);
        while (msg.size() > cut) void'(msg.pop_back());
      end
      2: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
      default: ;
    endcase
  endfunction

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         typed;
    rec_t       close;
  } row_t;

  row_t table_rows[$];

  function void add_row(logic [7:0] b, logic last = 1'b0, bit typed = 1'b0,
                        logic [3:0] kind = MSG_BEGIN, logic [2:0] st = STS_OK);
    row_t r;
    r.b = b; r.last = last; r.typed = typed;
    r.close = '{message_type: kind, field_code: FC_CLOSE, field_value: '0,
                region_length: '0, status: st, end_of_message: 1'b1};
    table_rows.insert(table_rows.size(), r);
  endfunction

  initial begin
    int unsigned i;
    failed = 1'b0; no_idle = 1'b0; hold_req = 1'b0;
    beats_in = 0; recs_out = 0; msgs_sent = 0; idle_cycles = 0;
    parser_clear();
    use_typed <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(8'hFF, 1, 1, MSG_UNKNOWN, STS_BAD_TAG);
    add_row(TAG_MSG, 1, 1, MSG_IGNORED, STS_OK);
    add_row(TAG_BEGIN, 1, 1, MSG_BEGIN, STS_TRUNC);
    add_row(TAG_COMMIT); add_row(8'hFF, 1, 1, MSG_COMMIT, STS_TRUNC);
    add_row(TAG_REL); repeat (4) add_row(8'h00); add_row(8'hFF, 1, 1, MSG_RELATION, STS_UNTERM);
    add_row(TAG_INS); repeat (4) add_row(8'hFF); add_row(8'h00, 1, 1, MSG_INSERT, STS_NO_INS);
    add_row(TAG_UPD); repeat (4) add_row(8'h00); add_row(8'h00, 1, 1, MSG_UPDATE, STS_NO_UPD);
    add_row(TAG_DEL); repeat (4) add_row(8'h00); add_row(SUB_NEW, 1, 1, MSG_DELETE, STS_NO_DEL);
    add_row(8'h00, 1, 1, MSG_UNKNOWN, STS_BAD_TAG);
    foreach (table_rows[k]) begin
      use_typed <= table_rows[k].typed;
      typed_close <= table_rows[k].close;
      send_beat(table_rows[k].b, table_rows[k].last);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_recs.size() == 0);
    @(posedge clk);
    use_typed <= 1'b0;

    i = 0;
    while (beats_in < 440) begin
      if (i == 6) hold_req = 1'b1;
      if (i == 12) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_recs.size() == 0);
        @(posedge clk);
      end
      if (beats_in > 370) no_idle = 1'b1;
      build_message();
      foreach (msg[k]) send_beat(msg[k], k == msg.size() - 1);
      msgs_sent++;
      i++;
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    wait (pending_recs.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d table beats and %0d random messages: %0d beats in, %0d records out",
             table_rows.size(), msgs_sent, beats_in, recs_out);
    if (!failed && pending_recs.size() == 0) begin
      $display("logical_replication_message_parser_core: match");
    end else begin
      $display("logical_replication_message_parser_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lrmp_pkg.sv
rtl/core/lrmp_stream_if.sv
rtl/core/lrmp_front.sv
rtl/core/lrmp_queue.sv
rtl/core/logical_replication_message_parser_core.sv
verif/logical_replication_message_parser_core_test.sv
